// ----- rtl/vcl_pkg.sv -----
// Shared types and constants for the variable-coefficient 3D stencil block.
// No dependencies; every other file of the block but the checker takes names from here.
`timescale 1ns / 1ps
`default_nettype none

package vcl_pkg;

   // Q16.16 data format
   localparam int DATA_W    = 32;
   localparam int FRAC_W    = 16;
   localparam int CSR_IDX_W = 3;
   localparam int DIM_W     = 7;
   localparam int COORD_W   = 6;
   localparam int PLANE_W   = 16;

   localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;
   localparam logic [15:0]      DIM_MIN   = 16'd3;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ALPHA    = 3'd0,
      CSR_DHX      = 3'd1,
      CSR_DHY      = 3'd2,
      CSR_DHZ      = 3'd3,
      CSR_ROW_LEN  = 3'd4,
      CSR_ROWS     = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] alpha;
      logic signed [DATA_W-1:0] dhx;
      logic signed [DATA_W-1:0] dhy;
      logic signed [DATA_W-1:0] dhz;
      logic [DIM_W-1:0]         row_length;
      logic [DIM_W-1:0]         rows_per_plane;
   } gains_type;

   typedef struct packed {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [PLANE_W-1:0] plane;
   } coord_type;

   // neighborhood of one result cell, as read from the plane buffers
   typedef struct packed {
      logic                     valid;
      coord_type                pos;
      logic signed [DATA_W-1:0] x_c;
      logic signed [DATA_W-1:0] x_w;
      logic signed [DATA_W-1:0] x_e;
      logic signed [DATA_W-1:0] x_s;
      logic signed [DATA_W-1:0] x_n;
      logic signed [DATA_W-1:0] x_b;
      logic signed [DATA_W-1:0] x_t;
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] bx_lo;
      logic signed [DATA_W-1:0] bx_hi;
      logic signed [DATA_W-1:0] by_lo;
      logic signed [DATA_W-1:0] by_hi;
      logic signed [DATA_W-1:0] bz_lo;
      logic signed [DATA_W-1:0] bz_hi;
   } stencil_type;

endpackage

`default_nettype wire

// ----- rtl/vcl_if.sv -----
// Channel interfaces of the stencil block: cell input, result output, register writes.
// Depends on vcl_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface vcl_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [vcl_pkg::DATA_W-1:0] x_value;
   logic signed [vcl_pkg::DATA_W-1:0] a_coef;
   logic signed [vcl_pkg::DATA_W-1:0] bx_face;
   logic signed [vcl_pkg::DATA_W-1:0] by_face;
   logic signed [vcl_pkg::DATA_W-1:0] bz_face;
   logic                              grid_start;

   modport source (output valid, x_value, a_coef, bx_face, by_face, bz_face, grid_start,
                   input ready);
   modport sink   (input valid, x_value, a_coef, bx_face, by_face, bz_face, grid_start,
                   output ready);
endinterface

interface vcl_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [vcl_pkg::DATA_W-1:0]  y_value;
   logic [vcl_pkg::COORD_W-1:0]        out_col;
   logic [vcl_pkg::COORD_W-1:0]        out_row;
   logic [vcl_pkg::PLANE_W-1:0]        out_plane;
   logic                               saturated;

   modport source (output valid, y_value, out_col, out_row, out_plane, saturated,
                   input ready);
   modport sink   (input valid, y_value, out_col, out_row, out_plane, saturated,
                   output ready);
endinterface

interface vcl_csr_if;
   logic                               valid;
   logic                               ready;
   logic [vcl_pkg::CSR_IDX_W-1:0]      index;
   logic [vcl_pkg::DATA_W-1:0]         data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/vcl_csr.sv -----
// Configuration registers: alpha, the three beta/h^2 gains and the grid dimensions.
// Depends on vcl_pkg and vcl_csr_if.
`timescale 1ns / 1ps
`default_nettype none

module vcl_csr (
   input  wire logic           clock,
   input  wire logic           reset,
   vcl_csr_if.sink             csr_chan,
   output vcl_pkg::gains_type  gains
);

   vcl_pkg::gains_type gains_ff, gains_in;

   assign csr_chan.ready = 1'b1;

   // register write decode; unknown indexes are dropped
   always_comb begin
      gains_in = gains_ff;
      if (csr_chan.valid) begin
         case (vcl_pkg::csr_index_type'(csr_chan.index))
            vcl_pkg::CSR_ALPHA:   gains_in.alpha = $signed(csr_chan.data);
            vcl_pkg::CSR_DHX:     gains_in.dhx   = $signed(csr_chan.data);
            vcl_pkg::CSR_DHY:     gains_in.dhy   = $signed(csr_chan.data);
            vcl_pkg::CSR_DHZ:     gains_in.dhz   = $signed(csr_chan.data);
            vcl_pkg::CSR_ROW_LEN: gains_in.row_length = csr_chan.data[vcl_pkg::DIM_W-1:0];
            vcl_pkg::CSR_ROWS:    gains_in.rows_per_plane = csr_chan.data[vcl_pkg::DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.alpha          <= '0;
         gains_ff.dhx            <= '0;
         gains_ff.dhy            <= '0;
         gains_ff.dhz            <= '0;
         gains_ff.row_length     <= vcl_pkg::DIM_RESET;
         gains_ff.rows_per_plane <= vcl_pkg::DIM_RESET;
      end else begin
         gains_ff <= gains_in;
      end
   end

   assign gains = gains_ff;

endmodule

`default_nettype wire

// ----- rtl/vcl_buffer.sv -----
// Raster position counters and plane buffers; gathers the seven-point neighborhood.
// Depends on vcl_pkg and vcl_req_if.
`timescale 1ns / 1ps
`default_nettype none

module vcl_buffer #(
   parameter int MAX_ROW  = 64,
   parameter int MAX_ROWS = 64
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           advance,
   input  vcl_pkg::gains_type  gains,
   vcl_req_if.sink             req_chan,
   output vcl_pkg::stencil_type stn
);

   localparam int CW      = (MAX_ROW  > 2) ? $clog2(MAX_ROW)  : 1;
   localparam int RW      = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
   localparam int CELL_AW = CW + RW;
   localparam int X_AW    = CELL_AW + 1;
   localparam int C_DEPTH = 1 << CELL_AW;
   localparam int X_DEPTH = 1 << X_AW;
   localparam logic [15:0] LEN_MAX  = 16'(MAX_ROW);
   localparam logic [15:0] ROWS_MAX = 16'(MAX_ROWS);
   localparam int DW = vcl_pkg::DATA_W;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [15:0]   plane_ff, plane_in;
   logic [1:0]    depth_ff, depth_in;

   logic          accept;
   logic [15:0]   len_c, rows_c, len16, rows16, c16, r16;
   logic [CW-1:0] c, c_m, c_p;
   logic [RW-1:0] r, r_m, r_p;
   logic [15:0]   p;
   logic [1:0]    d;
   logic          cur, want;

   // x copies, each read at two addresses; two planes each
   logic [DW-1:0] x0_mem [X_DEPTH];
   logic [DW-1:0] x1_mem [X_DEPTH];
   logic [DW-1:0] x2_mem [X_DEPTH];
   // coefficient planes
   logic [DW-1:0] a_mem  [C_DEPTH];
   logic [DW-1:0] bx_mem [C_DEPTH];
   logic [DW-1:0] by_mem [C_DEPTH];
   logic [DW-1:0] bz_mem [C_DEPTH];

   logic [DW-1:0] x_w_ff, x_e_ff, x_s_ff, x_n_ff, x_c_ff, x_b_ff;
   logic [DW-1:0] a_ff, bx_lo_ff, bx_hi_ff, by_lo_ff, by_hi_ff, bz_lo_ff;
   logic [DW-1:0] x_t_ff, bz_hi_ff;
   logic          valid_ff;
   vcl_pkg::coord_type pos_ff;

   assign accept         = req_chan.valid & advance;
   assign req_chan.ready = advance;

   // clamp grid dimensions to the supported range
   always_comb begin
      len16  = {9'd0, gains.row_length};
      rows16 = {9'd0, gains.rows_per_plane};
      if (len16 < vcl_pkg::DIM_MIN)       len_c = vcl_pkg::DIM_MIN;
      else if (len16 > LEN_MAX)           len_c = LEN_MAX;
      else                                len_c = len16;
      if (rows16 < vcl_pkg::DIM_MIN)      rows_c = vcl_pkg::DIM_MIN;
      else if (rows16 > ROWS_MAX)         rows_c = ROWS_MAX;
      else                                rows_c = rows16;
   end

   // position of the arriving cell; grid start clears it first
   always_comb begin
      c   = req_chan.grid_start ? '0 : col_ff;
      r   = req_chan.grid_start ? '0 : row_ff;
      p   = req_chan.grid_start ? '0 : plane_ff;
      d   = req_chan.grid_start ? '0 : depth_ff;
      c16 = 16'(c);
      r16 = 16'(r);
      c_m = c - CW'(1);
      c_p = c + CW'(1);
      r_m = r - RW'(1);
      r_p = r + RW'(1);
      cur = p[0];
      want = (d == 2'd2) && (c != '0) && (c16 + 16'd2 <= len_c)
             && (r != '0) && (r16 + 16'd2 <= rows_c);
   end

   // next raster position
   always_comb begin
      col_in   = CW'(c16 + 16'd1);
      row_in   = r;
      plane_in = p;
      depth_in = d;
      if (c16 + 16'd1 >= len_c) begin
         col_in = '0;
         row_in = RW'(r16 + 16'd1);
         if (r16 + 16'd1 >= rows_c) begin
            row_in   = '0;
            plane_in = p + 16'd1;
            depth_in = (d == 2'd2) ? d : d + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         plane_ff <= '0;
         depth_ff <= '0;
      end else if (accept) begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         plane_ff <= plane_in;
         depth_ff <= depth_in;
      end
   end

   // plane buffers: read the neighborhood, then store the arriving cell
   always_ff @(posedge clock) begin
      if (accept) begin
         x_w_ff   <= x0_mem[{~cur, r, c_m}];
         x_e_ff   <= x0_mem[{~cur, r, c_p}];
         x_s_ff   <= x1_mem[{~cur, r_m, c}];
         x_n_ff   <= x1_mem[{~cur, r_p, c}];
         x_c_ff   <= x2_mem[{~cur, r, c}];
         x_b_ff   <= x2_mem[{cur, r, c}];
         x0_mem[{cur, r, c}] <= req_chan.x_value;
         x1_mem[{cur, r, c}] <= req_chan.x_value;
         x2_mem[{cur, r, c}] <= req_chan.x_value;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_ff     <= a_mem[{r, c}];
         bx_lo_ff <= bx_mem[{r, c}];
         bx_hi_ff <= bx_mem[{r, c_p}];
         by_lo_ff <= by_mem[{r, c}];
         by_hi_ff <= by_mem[{r_p, c}];
         bz_lo_ff <= bz_mem[{r, c}];
         a_mem[{r, c}]  <= req_chan.a_coef;
         bx_mem[{r, c}] <= req_chan.bx_face;
         by_mem[{r, c}] <= req_chan.by_face;
         bz_mem[{r, c}] <= req_chan.bz_face;
      end
   end

   // upper neighbors and coordinates travel beside the buffer reads
   always_ff @(posedge clock) begin
      if (accept) begin
         x_t_ff       <= req_chan.x_value;
         bz_hi_ff     <= req_chan.bz_face;
         pos_ff.col   <= vcl_pkg::COORD_W'(c);
         pos_ff.row   <= vcl_pkg::COORD_W'(r);
         pos_ff.plane <= p - 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= accept & want;
      end
   end

   always_comb begin
      stn.valid = valid_ff;
      stn.pos   = pos_ff;
      stn.x_c   = $signed(x_c_ff);
      stn.x_w   = $signed(x_w_ff);
      stn.x_e   = $signed(x_e_ff);
      stn.x_s   = $signed(x_s_ff);
      stn.x_n   = $signed(x_n_ff);
      stn.x_b   = $signed(x_b_ff);
      stn.x_t   = $signed(x_t_ff);
      stn.a     = $signed(a_ff);
      stn.bx_lo = $signed(bx_lo_ff);
      stn.bx_hi = $signed(bx_hi_ff);
      stn.by_lo = $signed(by_lo_ff);
      stn.by_hi = $signed(by_hi_ff);
      stn.bz_lo = $signed(bz_lo_ff);
      stn.bz_hi = $signed(bz_hi_ff);
   end

endmodule

`default_nettype wire

// ----- rtl/vcl_datapath.sv -----
// Fixed-point arithmetic pipeline: differences, face fluxes, gain products, sum, saturation.
// Depends on vcl_pkg and vcl_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module vcl_datapath (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            advance,
   input  vcl_pkg::gains_type   gains,
   input  vcl_pkg::stencil_type stn,
   vcl_rsp_if.source            rsp_chan
);

   localparam int DW = vcl_pkg::DATA_W;
   localparam int FW = vcl_pkg::FRAC_W;

   // stage 2: differences and alpha*a
   logic                      v2_ff;
   vcl_pkg::coord_type        pos2_ff;
   logic signed [DW-1:0]      xc2_ff;
   logic signed [DW-1:0]      b2_ff [6];
   logic signed [DW:0]        d2_ff [6];
   logic signed [2*DW-1:0]    pa2_ff;
   logic signed [DW:0]        d2_in [6];
   logic signed [DW-1:0]      b2_in [6];

   // stage 3: flux products and split a*x products
   logic                      v3_ff;
   vcl_pkg::coord_type        pos3_ff;
   logic signed [2*DW:0]      fp3_ff [6];
   logic signed [2*DW-1:0]    axh3_ff;
   logic signed [DW+FW:0]     axl3_ff;

   // stage 4: flux difference per axis, a*x term
   logic                      v4_ff;
   vcl_pkg::coord_type        pos4_ff;
   logic signed [49:0]        fd4_ff [3];
   logic signed [65:0]        ax4_ff;

   // stage 5: gain products, split in high and low parts
   logic                      v5_ff;
   vcl_pkg::coord_type        pos5_ff;
   logic signed [65:0]        tph5_ff [3];
   logic signed [DW+FW:0]     tpl5_ff [3];
   logic signed [65:0]        ax5_ff;
   logic signed [DW-1:0]      g5 [3];

   // stage 6: negated axis terms, wrapped to 64 bits
   logic                      v6_ff;
   vcl_pkg::coord_type        pos6_ff;
   logic signed [63:0]        nt6_ff [3];
   logic signed [65:0]        ax6_ff;
   logic signed [63:0]        tsum6 [3];

   // stage 7: partial sums
   logic                      v7_ff;
   vcl_pkg::coord_type        pos7_ff;
   logic signed [65:0]        sa7_ff, sb7_ff;

   // output register
   logic                      rsp_valid_ff;
   logic signed [DW-1:0]      y_ff;
   logic                      sat_ff;
   vcl_pkg::coord_type        pos8_ff;
   logic signed [65:0]        s8;
   logic                      fits8;

   always_comb begin
      b2_in[0] = stn.bx_hi;  d2_in[0] = $signed({stn.x_e[DW-1], stn.x_e})
                                      - $signed({stn.x_c[DW-1], stn.x_c});
      b2_in[1] = stn.bx_lo;  d2_in[1] = $signed({stn.x_c[DW-1], stn.x_c})
                                      - $signed({stn.x_w[DW-1], stn.x_w});
      b2_in[2] = stn.by_hi;  d2_in[2] = $signed({stn.x_n[DW-1], stn.x_n})
                                      - $signed({stn.x_c[DW-1], stn.x_c});
      b2_in[3] = stn.by_lo;  d2_in[3] = $signed({stn.x_c[DW-1], stn.x_c})
                                      - $signed({stn.x_s[DW-1], stn.x_s});
      b2_in[4] = stn.bz_hi;  d2_in[4] = $signed({stn.x_t[DW-1], stn.x_t})
                                      - $signed({stn.x_c[DW-1], stn.x_c});
      b2_in[5] = stn.bz_lo;  d2_in[5] = $signed({stn.x_c[DW-1], stn.x_c})
                                      - $signed({stn.x_b[DW-1], stn.x_b});
   end

   assign g5[0] = gains.dhx;
   assign g5[1] = gains.dhy;
   assign g5[2] = gains.dhz;

   // 64-bit wrapped axis term: g*floor(d/2^16) + floor(g*(d mod 2^16)/2^16)
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         tsum6[k] = 64'(tph5_ff[k]) + 64'(tpl5_ff[k] >>> FW);
      end
   end

   // final sum and saturation check
   always_comb begin
      s8    = sa7_ff + sb7_ff;
      fits8 = (&s8[65:DW-1]) | ~(|s8[65:DW-1]);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v2_ff        <= stn.valid;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         v7_ff        <= v6_ff;
         rsp_valid_ff <= v7_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (advance) begin
         pos2_ff <= stn.pos;
         xc2_ff  <= stn.x_c;
         pa2_ff  <= gains.alpha * stn.a;
         for (int k = 0; k < 6; k++) begin
            b2_ff[k] <= b2_in[k];
            d2_ff[k] <= d2_in[k];
         end

         pos3_ff <= pos2_ff;
         for (int k = 0; k < 6; k++) begin
            fp3_ff[k] <= b2_ff[k] * d2_ff[k];
         end
         axh3_ff <= xc2_ff * $signed(pa2_ff[2*DW-1:DW]);
         axl3_ff <= xc2_ff * $signed({1'b0, pa2_ff[DW-1:FW]});

         pos4_ff <= pos3_ff;
         for (int k = 0; k < 3; k++) begin
            fd4_ff[k] <= 50'(fp3_ff[2*k] >>> FW) - 50'(fp3_ff[2*k+1] >>> FW);
         end
         ax4_ff <= 66'(axh3_ff) + 66'(axl3_ff >>> FW);

         pos5_ff <= pos4_ff;
         for (int k = 0; k < 3; k++) begin
            tph5_ff[k] <= g5[k] * $signed(fd4_ff[k][49:FW]);
            tpl5_ff[k] <= g5[k] * $signed({1'b0, fd4_ff[k][FW-1:0]});
         end
         ax5_ff <= ax4_ff;

         pos6_ff <= pos5_ff;
         for (int k = 0; k < 3; k++) begin
            nt6_ff[k] <= 64'sd0 - tsum6[k];
         end
         ax6_ff <= ax5_ff;

         pos7_ff <= pos6_ff;
         sa7_ff  <= ax6_ff + 66'(nt6_ff[0]);
         sb7_ff  <= 66'(nt6_ff[1]) + 66'(nt6_ff[2]);

         pos8_ff <= pos7_ff;
         sat_ff  <= ~fits8;
         if (fits8)       y_ff <= s8[DW-1:0];
         else if (s8[65]) y_ff <= {1'b1, {(DW-1){1'b0}}};
         else             y_ff <= {1'b0, {(DW-1){1'b1}}};
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.y_value   = y_ff;
   assign rsp_chan.out_col   = pos8_ff.col;
   assign rsp_chan.out_row   = pos8_ff.row;
   assign rsp_chan.out_plane = pos8_ff.plane;
   assign rsp_chan.saturated = sat_ff;

endmodule

`default_nettype wire

// ----- rtl/variable_coef_laplacian_3d_top.sv -----
// An accepted cell is registered in the buffer, in each datapath stage and on the output register.
// Throughput: one cell per cycle; the whole pipeline holds only while a result
// waits on the output register with rsp ready low.
// Reset clears position counters, valid bits and registers (dimensions 64 x 64).
// Plane buffers are not cleared: results start once two planes of a grid are in.
`timescale 1ns / 1ps
`default_nettype none

module variable_coef_laplacian_3d_top #(
   parameter int MAX_ROW  = 64,
   parameter int MAX_ROWS = 64
) (
   input  wire logic   clock,
   input  wire logic   reset,
   vcl_req_if.sink     req_chan,
   vcl_rsp_if.source   rsp_chan,
   vcl_csr_if.sink     csr_chan
);

   vcl_pkg::gains_type   gains;
   vcl_pkg::stencil_type stn;
   logic                 advance;

   // global pipeline enable from the output register
   assign advance = ~rsp_chan.valid | rsp_chan.ready;

   vcl_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .gains    (gains)
   );

   vcl_buffer #(
      .MAX_ROW  (MAX_ROW),
      .MAX_ROWS (MAX_ROWS)
   ) u_buffer (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .gains    (gains),
      .req_chan (req_chan),
      .stn      (stn)
   );

   vcl_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .gains    (gains),
      .stn      (stn),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

// ----- rtl/vcl_checker.sv -----
// Port-level checks for the stencil block, attached to the top level by bind.
// Depends only on the top level's channel signals.
`timescale 1ns / 1ps
`default_nettype none

module vcl_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] y_value,
   input wire logic        saturated,
   input wire logic [15:0] out_plane
);

   // a pending result transaction stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // its value, plane and saturated flag do not change while stalled
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(y_value) && $stable(out_plane)
                                  && $stable(saturated))
      else $error("result payload changed while stalled");

   // input is refused only under output backpressure
   a_ready: assert property (@(posedge clock)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output backpressure");

   // a clipped result sits at one of the range limits
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && saturated |-> y_value == 32'h7fff_ffff || y_value == 32'h8000_0000)
      else $error("saturated flag with unclipped value");

   // no result right after reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind variable_coef_laplacian_3d_top vcl_checker u_vcl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .y_value   (rsp_chan.y_value),
   .saturated (rsp_chan.saturated),
   .out_plane (rsp_chan.out_plane)
);

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for variable_coef_laplacian_3d_top: streams grids of cells
// and compares every result against an in-bench stencil predictor.
// Depends on vcl_pkg, the vcl channel interfaces and the top-level RTL.
`timescale 1ns / 1ps

module tb;

   localparam int ROW_SLOTS   = 64;
   localparam int PLANE_SLOTS = 64 * 64;
   localparam int DRAIN_WAIT  = 24;

   typedef struct {
      logic signed [vcl_pkg::DATA_W-1:0] x;
      logic signed [vcl_pkg::DATA_W-1:0] a;
      logic signed [vcl_pkg::DATA_W-1:0] bx;
      logic signed [vcl_pkg::DATA_W-1:0] by;
      logic signed [vcl_pkg::DATA_W-1:0] bz;
      logic                              start;
   } item_type;

   typedef struct {
      logic signed [vcl_pkg::DATA_W-1:0] y;
      logic [vcl_pkg::COORD_W-1:0]       col;
      logic [vcl_pkg::COORD_W-1:0]       row;
      logic [vcl_pkg::PLANE_W-1:0]       plane;
      logic                              sat;
   } result_type;

   // value kinds for cell content
   localparam int VAL_FULL    = 0;
   localparam int VAL_SMALL   = 1;
   localparam int VAL_EXTREME = 2;

   logic clock;
   logic reset;

   vcl_req_if req_bus ();
   vcl_rsp_if rsp_bus ();
   vcl_csr_if csr_bus ();

   variable_coef_laplacian_3d_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // predictor state: two x planes, one plane of each coefficient
   logic signed [vcl_pkg::DATA_W-1:0] x_hist  [0:2*PLANE_SLOTS-1];
   logic signed [vcl_pkg::DATA_W-1:0] a_hist  [0:PLANE_SLOTS-1];
   logic signed [vcl_pkg::DATA_W-1:0] bx_hist [0:PLANE_SLOTS-1];
   logic signed [vcl_pkg::DATA_W-1:0] by_hist [0:PLANE_SLOTS-1];
   logic signed [vcl_pkg::DATA_W-1:0] bz_hist [0:PLANE_SLOTS-1];
   int                          col_pos, row_pos, planes_seen;
   logic [vcl_pkg::PLANE_W-1:0] plane_pos;

   // register shadow
   logic signed [vcl_pkg::DATA_W-1:0] alpha_q, dhx_q, dhy_q, dhz_q;
   logic [vcl_pkg::DIM_W-1:0]         row_len_q, rows_q;

   result_type pending_results[$];
   int  mismatch_count;
   bit  steady;        // no idling on either side
   int  rsp_hold_left; // long receiver hold-off, counted by the ready process

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

   // floor(a*b / 2^16), exact
   function automatic logic signed [127:0] qmul(input logic signed [127:0] p,
                                               input logic signed [127:0] q);
      return (p * q) >>> vcl_pkg::FRAC_W;
   endfunction

   function automatic logic signed [127:0] axis_flux(input logic signed [127:0] dh,
         input logic signed [127:0] b_lo, input logic signed [127:0] b_hi,
         input logic signed [127:0] x_lo, input logic signed [127:0] x_c,
         input logic signed [127:0] x_hi);
      return qmul(dh, qmul(b_hi, x_hi - x_c) - qmul(b_lo, x_c - x_lo));
   endfunction

   function automatic int clamp_dim(input logic [vcl_pkg::DIM_W-1:0] v);
      if (v < 3) return 3;
      if (v > 64) return 64;
      return int'(v);
   endfunction

   // advance the stencil predictor by one accepted cell
   task automatic predict_cell(input item_type item);
      int len, rows, c, r, idx, cur, prv;
      logic signed [127:0] xc, t, ax, tx, ty, tz, sum;
      result_type res;
      len  = clamp_dim(row_len_q);
      rows = clamp_dim(rows_q);
      if (item.start) begin
         col_pos = 0;
         row_pos = 0;
         plane_pos = '0;
         planes_seen = 0;
      end
      c   = col_pos % ROW_SLOTS;
      r   = row_pos % 64;
      idx = r * ROW_SLOTS + c;
      cur = plane_pos[0] ? PLANE_SLOTS : 0;
      prv = PLANE_SLOTS - cur;
      if (planes_seen >= 2 && c >= 1 && c + 2 <= len && r >= 1 && r + 2 <= rows) begin
         xc  = x_hist[prv+idx];
         t   = qmul(alpha_q, a_hist[idx]);
         ax  = qmul(xc, t);
         tx  = axis_flux(dhx_q, bx_hist[idx], bx_hist[idx+1],
                         x_hist[prv+idx-1], xc, x_hist[prv+idx+1]);
         ty  = axis_flux(dhy_q, by_hist[idx], by_hist[idx+ROW_SLOTS],
                         x_hist[prv+idx-ROW_SLOTS], xc, x_hist[prv+idx+ROW_SLOTS]);
         tz  = axis_flux(dhz_q, bz_hist[idx], item.bz, x_hist[cur+idx], xc, item.x);
         sum = ax - tx - ty - tz;
         res.sat = 1'b1;
         if (sum > 128'sd2147483647)
            res.y = 32'h7FFF_FFFF;
         else if (sum < -128'sd2147483648)
            res.y = 32'h8000_0000;
         else begin
            res.y   = sum[31:0];
            res.sat = 1'b0;
         end
         res.col   = c[vcl_pkg::COORD_W-1:0];
         res.row   = r[vcl_pkg::COORD_W-1:0];
         res.plane = plane_pos - 16'd1;
         pending_results = {pending_results, res};
      end
      x_hist[cur+idx] = item.x;
      a_hist[idx]  = item.a;
      bx_hist[idx] = item.bx;
      by_hist[idx] = item.by;
      bz_hist[idx] = item.bz;
      col_pos = c + 1;
      if (col_pos >= len) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= rows) begin
            row_pos = 0;
            plane_pos = plane_pos + 16'd1;
            if (planes_seen < 2) planes_seen++;
         end
      end
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("ERROR at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0)
            report_mismatch("unexpected result y", rsp_bus.y_value, 0);
         else begin
            want = pending_results.pop_front();
            if (rsp_bus.y_value !== want.y)     report_mismatch("y_value", rsp_bus.y_value, want.y);
            if (rsp_bus.out_col !== want.col)   report_mismatch("out_col", rsp_bus.out_col, want.col);
            if (rsp_bus.out_row !== want.row)   report_mismatch("out_row", rsp_bus.out_row, want.row);
            if (rsp_bus.out_plane !== want.plane)
               report_mismatch("out_plane", rsp_bus.out_plane, want.plane);
            if (rsp_bus.saturated !== want.sat)
               report_mismatch("saturated", rsp_bus.saturated, want.sat);
         end
      end
   end

   // receiver: random stalls, occasional long hold-off
   initial begin
      int roll, stall_left;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         roll = $urandom_range(0, 99);
         if (rsp_hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            rsp_hold_left--;
         end else if (steady)
            rsp_bus.ready = 1'b1;
         else if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else if (roll < 20) begin
            rsp_bus.ready = 1'b0;
            stall_left = $urandom_range(0, 2);
         end else if (roll < 23) begin
            rsp_bus.ready = 1'b0;
            stall_left = $urandom_range(4, 30);
         end else
            rsp_bus.ready = 1'b1;
      end
   end

   function automatic int sender_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 65) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   function automatic logic signed [vcl_pkg::DATA_W-1:0] pick_value(input int kind);
      case (kind)
         VAL_FULL:  return $urandom;
         VAL_SMALL: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
         default: begin
            case ($urandom_range(0, 4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               3: return 32'hFFFF_FFFF;
               default: return 32'h0001_0000;
            endcase
         end
      endcase
   endfunction

   // one cell transaction; called at a falling edge, returns at a falling edge
   task automatic send_cell(input item_type item);
      int gap;
      req_bus.x_value    = item.x;
      req_bus.a_coef     = item.a;
      req_bus.bx_face    = item.bx;
      req_bus.by_face    = item.by;
      req_bus.bz_face    = item.bz;
      req_bus.grid_start = item.start;
      req_bus.valid      = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      predict_cell(item);
      @(negedge clock);
      gap = sender_gap();
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic write_csr(input vcl_pkg::csr_index_type which,
                            input logic [vcl_pkg::DATA_W-1:0] value);
      csr_bus.index = which;
      csr_bus.data  = value;
      csr_bus.valid = 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      case (which)
         vcl_pkg::CSR_ALPHA:   alpha_q   = value;
         vcl_pkg::CSR_DHX:     dhx_q     = value;
         vcl_pkg::CSR_DHY:     dhy_q     = value;
         vcl_pkg::CSR_DHZ:     dhz_q     = value;
         vcl_pkg::CSR_ROW_LEN: row_len_q = value[vcl_pkg::DIM_W-1:0];
         vcl_pkg::CSR_ROWS:    rows_q    = value[vcl_pkg::DIM_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic set_gains(input logic [vcl_pkg::DATA_W-1:0] alpha,
                            input logic [vcl_pkg::DATA_W-1:0] dhx,
                            input logic [vcl_pkg::DATA_W-1:0] dhy,
                            input logic [vcl_pkg::DATA_W-1:0] dhz);
      write_csr(vcl_pkg::CSR_ALPHA, alpha);
      write_csr(vcl_pkg::CSR_DHX, dhx);
      write_csr(vcl_pkg::CSR_DHY, dhy);
      write_csr(vcl_pkg::CSR_DHZ, dhz);
   endtask

   // wait for all expected results, then for the pipeline to empty
   task automatic drain();
      req_bus.valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      @(negedge clock);
   endtask

   // stream a grid in raster order; stop early after cut cells if cut > 0
   task automatic stream_grid(input int planes, input int kind, input int cut, output int sent);
      int len, rows, total;
      item_type item;
      len   = clamp_dim(row_len_q);
      rows  = clamp_dim(rows_q);
      total = len * rows * planes;
      if (cut > 0 && cut < total) total = cut;
      for (sent = 0; sent < total; sent++) begin
         item.x  = pick_value(kind);
         item.a  = pick_value(kind);
         item.bx = pick_value(kind);
         item.by = pick_value(kind);
         item.bz = pick_value(kind);
         item.start = (sent == 0);
         send_cell(item);
      end
   endtask

   function automatic logic [vcl_pkg::DATA_W-1:0] pick_gain();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         default: return $urandom_range(0, 1 << 18) - (1 << 17);
      endcase
   endfunction

   // smallest grid, extreme field values and extreme gains, then small values with alpha alone
   task automatic test_extremes();
      int n;
      write_csr(vcl_pkg::CSR_ROW_LEN, 3);
      write_csr(vcl_pkg::CSR_ROWS, 3);
      set_gains(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      stream_grid(3, VAL_EXTREME, 0, n);
      drain();
      set_gains(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      stream_grid(3, VAL_EXTREME, 0, n);
      drain();
      set_gains(32'h0001_0000, 32'h0, 32'h0, 32'h0);
      stream_grid(3, VAL_SMALL, 0, n);
      drain();
   endtask

   // dimension registers outside 3..64 act as the nearest bound
   task automatic test_dim_clamp();
      int n;
      set_gains(32'h0002_0000, 32'h0000_8000, 32'hFFFF_0000, 32'h0001_8000);
      write_csr(vcl_pkg::CSR_ROW_LEN, 0);
      write_csr(vcl_pkg::CSR_ROWS, 2);
      stream_grid(3, VAL_SMALL, 0, n);
      drain();
      // 64 x 3 planes: two whole planes, then part of the third
      write_csr(vcl_pkg::CSR_ROW_LEN, 100);
      write_csr(vcl_pkg::CSR_ROWS, 3);
      stream_grid(3, VAL_SMALL, 2 * 192 + 64 + 40, n);
      drain();
   endtask

   // tallest planes (rows register above range), no idling on either side
   task automatic test_largest_grid();
      int n;
      write_csr(vcl_pkg::CSR_ROW_LEN, 3);
      write_csr(vcl_pkg::CSR_ROWS, 127);
      steady = 1'b1;
      stream_grid(3, VAL_SMALL, 2 * 192 + 3 * 30, n);
      drain();
      steady = 1'b0;
   endtask

   // receiver holds off long enough that the block stalls its input
   task automatic test_backpressure();
      int n;
      write_csr(vcl_pkg::CSR_ROW_LEN, 8);
      write_csr(vcl_pkg::CSR_ROWS, 8);
      steady = 1'b1;
      rsp_hold_left = 400;
      stream_grid(3, VAL_SMALL, 0, n);
      drain();
      steady = 1'b0;
   endtask

   // random grids, mostly well formed, some cut short
   task automatic test_random_grids();
      int items, n, roll, kind, len, rows, planes, cut;
      items = 0;
      while (items < 200) begin
         roll = $urandom_range(0, 9);
         kind = roll < 7 ? VAL_SMALL : (roll < 9 ? VAL_FULL : VAL_EXTREME);
         if ($urandom_range(0, 7) == 0) begin
            len  = $urandom_range(20, 40);
            rows = 3;
         end else begin
            len  = $urandom_range(3, 10);
            rows = $urandom_range(3, 6);
         end
         planes = $urandom_range(2, 4);
         cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, len * rows * planes - 1) : 0;
         set_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain());
         write_csr(vcl_pkg::CSR_ROW_LEN, len);
         write_csr(vcl_pkg::CSR_ROWS, rows);
         stream_grid(planes, kind, cut, n);
         items += n;
         drain();
      end
   endtask

   initial begin
      mismatch_count = 0;
      steady        = 1'b0;
      rsp_hold_left = 0;
      req_bus.valid = 1'b0;
      req_bus.x_value = '0;
      req_bus.a_coef  = '0;
      req_bus.bx_face = '0;
      req_bus.by_face = '0;
      req_bus.bz_face = '0;
      req_bus.grid_start = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = vcl_pkg::CSR_ALPHA;
      csr_bus.data  = '0;
      alpha_q = '0;
      dhx_q   = '0;
      dhy_q   = '0;
      dhz_q   = '0;
      row_len_q = vcl_pkg::DIM_RESET;
      rows_q    = vcl_pkg::DIM_RESET;
      col_pos = 0;
      row_pos = 0;
      plane_pos = '0;
      planes_seen = 0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_extremes();
      test_dim_clamp();
      test_backpressure();
      test_random_grids();
      test_largest_grid();

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
